// ===== hdl/pcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcd_pkg: shared types and codes of the picture command decoder
// Holds the parse phase type, the primitive kinds, the command codes and the
// decoder state and result records.
// ----------------------------------------------------------------------------
package pcd_pkg;

	// Command bytes
	localparam logic [7:0] CMD_FIRST    = 8'hF0;
	localparam logic [7:0] CMD_VIS_ON   = 8'hF0;
	localparam logic [7:0] CMD_VIS_OFF  = 8'hF1;
	localparam logic [7:0] CMD_PRI_ON   = 8'hF2;
	localparam logic [7:0] CMD_PRI_OFF  = 8'hF3;
	localparam logic [7:0] CMD_Y_CORNER = 8'hF4;
	localparam logic [7:0] CMD_X_CORNER = 8'hF5;
	localparam logic [7:0] CMD_ABS_LINE = 8'hF6;
	localparam logic [7:0] CMD_REL_LINE = 8'hF7;
	localparam logic [7:0] CMD_FILL     = 8'hF8;
	localparam logic [7:0] CMD_PEN      = 8'hF9;
	localparam logic [7:0] CMD_BRUSH    = 8'hFA;
	localparam logic [7:0] CMD_END      = 8'hFF;

	localparam int unsigned PEN_SPLATTER_BIT = 5;

	typedef enum logic [2:0] {
		KIND_PIXEL = 3'd0,
		KIND_LINE  = 3'd1,
		KIND_BRUSH = 3'd2,
		KIND_FILL  = 3'd3,
		KIND_END   = 3'd4,
		KIND_ERROR = 3'd5
	} prim_kind_t;

	typedef enum logic [23:0] {
		PH_CMD   = 24'h000001,
		PH_VCOL  = 24'h000002,
		PH_PCOL  = 24'h000004,
		PH_PEN   = 24'h000008,
		PH_YC_X0 = 24'h000010,
		PH_YC_Y0 = 24'h000020,
		PH_YC_Y  = 24'h000040,
		PH_YC_X  = 24'h000080,
		PH_XC_X0 = 24'h000100,
		PH_XC_Y0 = 24'h000200,
		PH_XC_X  = 24'h000400,
		PH_XC_Y  = 24'h000800,
		PH_AB_X0 = 24'h001000,
		PH_AB_Y0 = 24'h002000,
		PH_AB_X  = 24'h004000,
		PH_AB_Y  = 24'h008000,
		PH_RL_X0 = 24'h010000,
		PH_RL_Y0 = 24'h020000,
		PH_RL_D  = 24'h040000,
		PH_BR_S  = 24'h080000,
		PH_BR_X  = 24'h100000,
		PH_BR_Y  = 24'h200000,
		PH_FL_X  = 24'h400000,
		PH_FL_Y  = 24'h800000
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] last_x;
		logic [7:0] last_y;
		logic [7:0] held_x;
		logic       visual_on;
		logic [7:0] visual_colour;
		logic       priority_on;
		logic [7:0] priority_colour;
		logic [7:0] pen_code;
		logic [6:0] splatter_index;
		logic       dirty;
		logic       halted;
	} pcd_state_t;

	localparam pcd_state_t STATE_RESET = '{
		phase:           PH_CMD,
		last_x:          8'd0,
		last_y:          8'd0,
		held_x:          8'd0,
		visual_on:       1'b0,
		visual_colour:   8'd0,
		priority_on:     1'b0,
		priority_colour: 8'd0,
		pen_code:        8'd0,
		splatter_index:  7'd0,
		dirty:           1'b0,
		halted:          1'b0
	};

	typedef struct packed {
		prim_kind_t kind;
		logic [7:0] from_x;
		logic [7:0] from_y;
		logic [7:0] to_x;
		logic [7:0] to_y;
		logic       visual_on;
		logic [7:0] visual_colour;
		logic       priority_on;
		logic [7:0] priority_colour;
		logic [7:0] pen_code;
		logic [6:0] splatter_index;
		logic       dirty;
	} pcd_result_t;

endpackage

// ===== hdl/picture_command_decoder.sv =====
// ----------------------------------------------------------------------------
// picture_command_decoder: picture command stream to drawing primitives
// Decodes one resource byte per cycle while in_stall is low, and gives pixels, lines, brush plots,
// fill points, end of picture and unknown code errors.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid / in_stall carry one beat per resource byte
//   (stream_byte, new_picture). new_picture clears the decoder state before
//   its byte is decoded, starting a fresh picture.
//   Output channel: out_valid / out_stall carry one primitive per beat, with
//   the drawing state (colours, enables, pen, splatter, dirty) after the byte.
//   A byte gives at most one primitive; most bytes give none.
//   A primitive is registered in the output register (or the skid register
//   if the output stalls). Throughput: one byte per cycle while in_stall is
//   low, set by the single decode pass between the state and result registers.
//   Stall: a skid register takes one result while the output is stalled;
//   in_stall rises only once that skid register is full, and falls in the
//   cycle after the output register frees up again.
//   Reset: arst_n clears the parser to await a command byte, drops all
//   enables and colours to zero and empties the output and skid registers.
//   After an end of picture or an unknown code the decoder ignores bytes
//   until a beat with new_picture set.
// ----------------------------------------------------------------------------
module picture_command_decoder import pcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] stream_byte,
	input  logic       new_picture,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] prim_kind,
	output logic [7:0] from_x,
	output logic [7:0] from_y,
	output logic [7:0] to_x,
	output logic [7:0] to_y,
	output logic       visual_on,
	output logic [7:0] visual_colour,
	output logic       priority_on,
	output logic [7:0] priority_colour,
	output logic [7:0] pen_code,
	output logic [6:0] splatter_index,
	output logic       picture_dirty
);

	pcd_state_t  state_q;
	pcd_state_t  state_d;
	pcd_result_t res;
	logic        res_valid;
	pcd_result_t out_q;
	logic        out_valid_q;
	pcd_result_t skid_q;
	logic        skid_valid_q;
	logic        accept;
	logic        res_fire;
	logic        out_free;

	// Decode the byte against the current parser state.
	pcd_decode u_decode (
		.state_q     (state_q),
		.stream_byte (stream_byte),
		.new_picture (new_picture),
		.state_d     (state_d),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Hold the input off only while the skid register is occupied.
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign res_fire = accept && res_valid;
	// The output register can be loaded when empty or being taken this cycle.
	assign out_free = !out_valid_q || !out_stall;

	// Advance the parser state on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= state_d;
		end
	end

	// Output and skid occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				// Drain the skid register first; no beat is accepted meanwhile.
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_fire;
			end
		end else if (res_fire) begin
			// Output stalled: park the new result in the skid register.
			skid_valid_q <= 1'b1;
		end
	end

	// Result payload, no reset needed.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (res_fire) begin
				out_q <= res;
			end
		end else if (res_fire) begin
			skid_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign prim_kind       = out_q.kind;
	assign from_x          = out_q.from_x;
	assign from_y          = out_q.from_y;
	assign to_x            = out_q.to_x;
	assign to_y            = out_q.to_y;
	assign visual_on       = out_q.visual_on;
	assign visual_colour   = out_q.visual_colour;
	assign priority_on     = out_q.priority_on;
	assign priority_colour = out_q.priority_colour;
	assign pen_code        = out_q.pen_code;
	assign splatter_index  = out_q.splatter_index;
	assign picture_dirty   = out_q.dirty;

endmodule

// ===== hdl/pcd_decode.sv =====
// ----------------------------------------------------------------------------
// pcd_decode: byte decode of the picture command decoder
// Works out the next parser state and the primitive, if any, for one byte.
// ----------------------------------------------------------------------------
module pcd_decode import pcd_pkg::*; (
	input  pcd_state_t  state_q,
	input  logic [7:0]  stream_byte,
	input  logic        new_picture,
	output pcd_state_t  state_d,
	output logic        res_valid,
	output pcd_result_t res
);

	function automatic logic is_checked(phase_t ph);
		logic chk;
		chk = 1'b0;
		case (ph) inside
			PH_YC_Y, PH_YC_X, PH_XC_X, PH_XC_Y, PH_AB_X, PH_AB_Y,
			PH_RL_D, PH_BR_S, PH_BR_X, PH_BR_Y, PH_FL_X, PH_FL_Y: chk = 1'b1;
			default: chk = 1'b0;
		endcase
		return chk;
	endfunction

	always_comb begin
		pcd_state_t s;
		pcd_state_t n;
		logic       go_cmd;
		logic [7:0] b;
		logic [7:0] dx;
		logic [7:0] dy;
		logic [7:0] nx;
		logic [7:0] ny;

		b      = stream_byte;
		s      = new_picture ? STATE_RESET : state_q;
		n      = s;
		go_cmd = 1'b0;
		dx     = b[7] ? (8'd0 - {5'd0, b[6:4]}) : {5'd0, b[6:4]};
		dy     = b[3] ? (8'd0 - {5'd0, b[2:0]}) : {5'd0, b[2:0]};
		nx     = s.last_x;
		ny     = s.last_y;

		res_valid  = 1'b0;
		res        = '0;
		res.kind   = KIND_PIXEL;

		if (!s.halted) begin
			if (is_checked(s.phase) && b >= CMD_FIRST) begin
				go_cmd = 1'b1;
			end else begin
				unique case (s.phase) inside
					PH_VCOL: begin
						n.visual_colour = b;
						n.visual_on     = 1'b1;
						n.phase         = PH_CMD;
					end
					PH_PCOL: begin
						n.priority_colour = b;
						n.priority_on     = 1'b1;
						n.phase           = PH_CMD;
					end
					PH_PEN: begin
						n.pen_code = b;
						n.phase    = PH_CMD;
					end
					PH_YC_X0: begin n.held_x = b; n.phase = PH_YC_Y0; end
					PH_XC_X0: begin n.held_x = b; n.phase = PH_XC_Y0; end
					PH_AB_X0: begin n.held_x = b; n.phase = PH_AB_Y0; end
					PH_RL_X0: begin n.held_x = b; n.phase = PH_RL_Y0; end
					PH_YC_Y0, PH_XC_Y0, PH_AB_Y0, PH_RL_Y0: begin
						n.last_x = s.held_x;
						n.last_y = b;
						case (s.phase) inside
							PH_YC_Y0: n.phase = PH_YC_Y;
							PH_XC_Y0: n.phase = PH_XC_X;
							PH_AB_Y0: n.phase = PH_AB_X;
							default:  n.phase = PH_RL_D;
						endcase
						res_valid  = 1'b1;
						res.kind   = KIND_PIXEL;
						res.from_x = s.held_x;
						res.from_y = b;
						res.to_x   = s.held_x;
						res.to_y   = b;
					end
					PH_YC_Y, PH_YC_X, PH_XC_X, PH_XC_Y, PH_AB_Y, PH_RL_D: begin
						case (s.phase) inside
							PH_YC_Y: begin ny = b; n.phase = PH_YC_X; end
							PH_YC_X: begin nx = b; n.phase = PH_YC_Y; end
							PH_XC_X: begin nx = b; n.phase = PH_XC_Y; end
							PH_XC_Y: begin ny = b; n.phase = PH_XC_X; end
							PH_AB_Y: begin nx = s.held_x; ny = b; n.phase = PH_AB_X; end
							default: begin nx = s.last_x + dx; ny = s.last_y + dy; end
						endcase
						n.last_x   = nx;
						n.last_y   = ny;
						res_valid  = 1'b1;
						res.kind   = KIND_LINE;
						res.from_x = s.last_x;
						res.from_y = s.last_y;
						res.to_x   = nx;
						res.to_y   = ny;
					end
					PH_AB_X: begin n.held_x = b; n.phase = PH_AB_Y; end
					PH_BR_S: begin
						n.splatter_index = b[7:1];
						n.phase          = PH_BR_X;
					end
					PH_BR_X: begin n.held_x = b; n.phase = PH_BR_Y; end
					PH_BR_Y: begin
						n.phase    = s.pen_code[PEN_SPLATTER_BIT] ? PH_BR_S : PH_BR_X;
						res_valid  = 1'b1;
						res.kind   = KIND_BRUSH;
						res.from_x = s.held_x;
						res.from_y = b;
						res.to_x   = s.held_x;
						res.to_y   = b;
					end
					PH_FL_X: begin n.held_x = b; n.phase = PH_FL_Y; end
					PH_FL_Y: begin
						n.phase    = PH_FL_X;
						res_valid  = 1'b1;
						res.kind   = KIND_FILL;
						res.from_x = s.held_x;
						res.from_y = b;
						res.to_x   = s.held_x;
						res.to_y   = b;
					end
					default: go_cmd = 1'b1;
				endcase
			end

			if (go_cmd) begin
				n.phase = PH_CMD;
				unique case (b)
					CMD_VIS_ON:   n.phase = PH_VCOL;
					CMD_VIS_OFF:  n.visual_on = 1'b0;
					CMD_PRI_ON:   n.phase = PH_PCOL;
					CMD_PRI_OFF:  n.priority_on = 1'b0;
					CMD_Y_CORNER: begin n.dirty = s.dirty | s.visual_on; n.phase = PH_YC_X0; end
					CMD_X_CORNER: begin n.dirty = s.dirty | s.visual_on; n.phase = PH_XC_X0; end
					CMD_ABS_LINE: begin n.dirty = s.dirty | s.visual_on; n.phase = PH_AB_X0; end
					CMD_REL_LINE: begin n.dirty = s.dirty | s.visual_on; n.phase = PH_RL_X0; end
					CMD_FILL:     begin n.dirty = s.dirty | s.visual_on; n.phase = PH_FL_X; end
					CMD_PEN:      n.phase = PH_PEN;
					CMD_BRUSH: begin
						n.dirty = s.dirty | s.visual_on;
						n.phase = s.pen_code[PEN_SPLATTER_BIT] ? PH_BR_S : PH_BR_X;
					end
					CMD_END: begin
						n.halted  = 1'b1;
						res_valid = 1'b1;
						res.kind  = KIND_END;
					end
					default: begin
						n.halted   = 1'b1;
						res_valid  = 1'b1;
						res.kind   = KIND_ERROR;
						res.from_x = b;
						res.to_x   = b;
					end
				endcase
			end
		end

		res.visual_on       = n.visual_on;
		res.visual_colour   = n.visual_colour;
		res.priority_on     = n.priority_on;
		res.priority_colour = n.priority_colour;
		res.pen_code        = n.pen_code;
		res.splatter_index  = n.splatter_index;
		res.dirty           = n.dirty;
		state_d             = n;
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the picture command decoder
// Feeds picture resource bytes through the valid/stall input channel and
// compares every primitive on the output channel with a cycle-free software
// decode of the same byte stream, kept inside the bench.
// ----------------------------------------------------------------------------
module tb import pcd_pkg::*; ();

	typedef struct packed {
		logic [7:0] data;
		logic       np;
	} beat_t;

	// Clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #10 clk = ~clk;

	// Block ports; every input starts from a known value
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic [7:0] stream_byte = 8'h00;
	logic       new_picture = 1'b0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic [2:0] prim_kind;
	logic [7:0] from_x;
	logic [7:0] from_y;
	logic [7:0] to_x;
	logic [7:0] to_y;
	logic       visual_on;
	logic [7:0] visual_colour;
	logic       priority_on;
	logic [7:0] priority_colour;
	logic [7:0] pen_code;
	logic [6:0] splatter_index;
	logic       picture_dirty;

	picture_command_decoder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.stream_byte    (stream_byte),
		.new_picture    (new_picture),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.prim_kind      (prim_kind),
		.from_x         (from_x),
		.from_y         (from_y),
		.to_x           (to_x),
		.to_y           (to_y),
		.visual_on      (visual_on),
		.visual_colour  (visual_colour),
		.priority_on    (priority_on),
		.priority_colour(priority_colour),
		.pen_code       (pen_code),
		.splatter_index (splatter_index),
		.picture_dirty  (picture_dirty)
	);

	// Bench bookkeeping
	beat_t       pending[$];          // bytes waiting to be offered
	pcd_result_t expected_prims[$];   // primitives the decode predicts, oldest first
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          fail_count     = 0;
	int          beats_queued   = 0;
	int          beats_taken    = 0;
	int          prims_checked  = 0;
	int          kind_seen[6];
	int          burst_asked    = 0;
	int          burst_served   = 0;
	int          burst_left     = 0;
	logic        np_next        = 1'b0;
	logic        np_noise_on    = 1'b0;
	logic [7:0]  gen_pen        = 8'h00;

	// ------------------------------------------------------------------------
	// Decoder prediction: parser phase, pen position and drawing state
	// ------------------------------------------------------------------------
	phase_t     dec_phase = PH_CMD;
	logic [7:0] pos_x     = 8'h00;
	logic [7:0] pos_y     = 8'h00;
	logic [7:0] held      = 8'h00;
	logic       vis_en    = 1'b0;
	logic [7:0] vis_col   = 8'h00;
	logic       pri_en    = 1'b0;
	logic [7:0] pri_col   = 8'h00;
	logic [7:0] pen       = 8'h00;
	logic [6:0] splat     = 7'h00;
	logic       dirty     = 1'b0;
	logic       halted_q  = 1'b0;

	task automatic clear_picture_state();
		dec_phase = PH_CMD;
		pos_x     = 8'h00;
		pos_y     = 8'h00;
		held      = 8'h00;
		vis_en    = 1'b0;
		vis_col   = 8'h00;
		pri_en    = 1'b0;
		pri_col   = 8'h00;
		pen       = 8'h00;
		splat     = 7'h00;
		dirty     = 1'b0;
		halted_q  = 1'b0;
	endtask

	// Record a primitive together with the drawing state as it now stands
	task automatic push_prim(prim_kind_t k, logic [7:0] fx, logic [7:0] fy,
			logic [7:0] tx, logic [7:0] ty);
		pcd_result_t r;
		r.kind            = k;
		r.from_x          = fx;
		r.from_y          = fy;
		r.to_x            = tx;
		r.to_y            = ty;
		r.visual_on       = vis_en;
		r.visual_colour   = vis_col;
		r.priority_on     = pri_en;
		r.priority_colour = pri_col;
		r.pen_code        = pen;
		r.splatter_index  = splat;
		r.dirty           = dirty;
		expected_prims.push_back(r);
	endtask

	task automatic start_drawing(phase_t p);
		if (vis_en) dirty = 1'b1;
		dec_phase = p;
	endtask

	task automatic line_to(logic [7:0] nx, logic [7:0] ny);
		push_prim(KIND_LINE, pos_x, pos_y, nx, ny);
		pos_x = nx;
		pos_y = ny;
	endtask

	// Sign-magnitude nibble: bit 3 is the sign, bits 2..0 the size
	function automatic logic [7:0] nibble_step(logic [3:0] n);
		logic [7:0] mag;
		mag = {5'b0, n[2:0]};
		return n[3] ? 8'h00 - mag : mag;
	endfunction

	function automatic logic coord_checked(phase_t p);
		return p inside {PH_YC_Y, PH_YC_X, PH_XC_X, PH_XC_Y, PH_AB_X, PH_AB_Y,
			PH_RL_D, PH_BR_S, PH_BR_X, PH_BR_Y, PH_FL_X, PH_FL_Y};
	endfunction

	task automatic decode_command(logic [7:0] b);
		dec_phase = PH_CMD;
		case (b)
			CMD_VIS_ON:   dec_phase = PH_VCOL;
			CMD_VIS_OFF:  vis_en = 1'b0;
			CMD_PRI_ON:   dec_phase = PH_PCOL;
			CMD_PRI_OFF:  pri_en = 1'b0;
			CMD_Y_CORNER: start_drawing(PH_YC_X0);
			CMD_X_CORNER: start_drawing(PH_XC_X0);
			CMD_ABS_LINE: start_drawing(PH_AB_X0);
			CMD_REL_LINE: start_drawing(PH_RL_X0);
			CMD_FILL:     start_drawing(PH_FL_X);
			CMD_PEN:      dec_phase = PH_PEN;
			CMD_BRUSH:    start_drawing(pen[PEN_SPLATTER_BIT] ? PH_BR_S : PH_BR_X);
			CMD_END: begin
				halted_q = 1'b1;
				push_prim(KIND_END, 8'h00, 8'h00, 8'h00, 8'h00);
			end
			default: begin
				halted_q = 1'b1;
				push_prim(KIND_ERROR, b, 8'h00, b, 8'h00);
			end
		endcase
	endtask

	// Advance the decode by one accepted beat
	task automatic decode_beat(logic [7:0] b, logic np);
		if (np) clear_picture_state();
		if (halted_q) return;
		// a checked byte of F0 or above ends the command and is decoded at once
		if (coord_checked(dec_phase) && b >= CMD_FIRST) begin
			decode_command(b);
			return;
		end
		case (dec_phase)
			PH_VCOL: begin
				vis_col   = b;
				vis_en    = 1'b1;
				dec_phase = PH_CMD;
			end
			PH_PCOL: begin
				pri_col   = b;
				pri_en    = 1'b1;
				dec_phase = PH_CMD;
			end
			PH_PEN: begin
				pen       = b;
				dec_phase = PH_CMD;
			end
			PH_YC_X0: begin held = b; dec_phase = PH_YC_Y0; end
			PH_XC_X0: begin held = b; dec_phase = PH_XC_Y0; end
			PH_AB_X0: begin held = b; dec_phase = PH_AB_Y0; end
			PH_RL_X0: begin held = b; dec_phase = PH_RL_Y0; end
			PH_YC_Y0, PH_XC_Y0, PH_AB_Y0, PH_RL_Y0: begin
				// the opening pair is taken unchecked and plots a pixel
				pos_x = held;
				pos_y = b;
				case (dec_phase)
					PH_YC_Y0: dec_phase = PH_YC_Y;
					PH_XC_Y0: dec_phase = PH_XC_X;
					PH_AB_Y0: dec_phase = PH_AB_X;
					default:  dec_phase = PH_RL_D;
				endcase
				push_prim(KIND_PIXEL, pos_x, pos_y, pos_x, pos_y);
			end
			PH_YC_Y: begin dec_phase = PH_YC_X; line_to(pos_x, b); end
			PH_YC_X: begin dec_phase = PH_YC_Y; line_to(b, pos_y); end
			PH_XC_X: begin dec_phase = PH_XC_Y; line_to(b, pos_y); end
			PH_XC_Y: begin dec_phase = PH_XC_X; line_to(pos_x, b); end
			PH_AB_X: begin held = b; dec_phase = PH_AB_Y; end
			PH_AB_Y: begin dec_phase = PH_AB_X; line_to(held, b); end
			PH_RL_D: line_to(pos_x + nibble_step(b[7:4]), pos_y + nibble_step(b[3:0]));
			PH_BR_S: begin splat = b[7:1]; dec_phase = PH_BR_X; end
			PH_BR_X: begin held = b; dec_phase = PH_BR_Y; end
			PH_BR_Y: begin
				dec_phase = pen[PEN_SPLATTER_BIT] ? PH_BR_S : PH_BR_X;
				push_prim(KIND_BRUSH, held, b, held, b);
			end
			PH_FL_X: begin held = b; dec_phase = PH_FL_Y; end
			PH_FL_Y: begin
				dec_phase = PH_FL_X;
				push_prim(KIND_FILL, held, b, held, b);
			end
			default: decode_command(b);
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Input driver: offer queued bytes, hold a stalled beat unchanged
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_beat(stream_byte, new_picture);
				beats_taken++;
			end
			// only move on once the current beat has gone or none is offered
			if (!in_valid || !in_stall) begin
				if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid    <= 1'b1;
					stream_byte <= pending[0].data;
					new_picture <= pending[0].np;
					void'(pending.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output stall: random back-pressure, plus long hold-offs on request
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (burst_left != 0) begin
			out_stall  <= 1'b1;
			burst_left <= burst_left - 1;
		end else if (burst_served != burst_asked) begin
			out_stall    <= 1'b1;
			burst_left   <= 299;
			burst_served <= burst_served + 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Output monitor: compare each accepted primitive with the oldest prediction
	// ------------------------------------------------------------------------
	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		pcd_result_t w;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_prims.size() == 0) begin
				$display("%0t: unexpected primitive, expected none, got kind %0d at %0h,%0h",
					$time, prim_kind, from_x, from_y);
				fail_count++;
			end else begin
				w = expected_prims.pop_front();
				check_field("prim_kind", 8'(w.kind), 8'(prim_kind));
				check_field("from_x", w.from_x, from_x);
				check_field("from_y", w.from_y, from_y);
				check_field("to_x", w.to_x, to_x);
				check_field("to_y", w.to_y, to_y);
				check_field("visual_on", 8'(w.visual_on), 8'(visual_on));
				check_field("visual_colour", w.visual_colour, visual_colour);
				check_field("priority_on", 8'(w.priority_on), 8'(priority_on));
				check_field("priority_colour", w.priority_colour, priority_colour);
				check_field("pen_code", w.pen_code, pen_code);
				check_field("splatter_index", 8'(w.splatter_index), 8'(splatter_index));
				check_field("picture_dirty", 8'(w.dirty), 8'(picture_dirty));
				if (int'(w.kind) < 6) kind_seen[int'(w.kind)]++;
				prims_checked++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------------
	task automatic add_beat(logic [7:0] b);
		beat_t t;
		t.data = b;
		// now and then clear the picture mid-stream to break a sequence
		t.np    = np_next || (np_noise_on && $urandom_range(0, 299) == 0);
		np_next = 1'b0;
		pending.push_back(t);
		beats_queued++;
	endtask

	// Bytes sent while the decoder is halted; they change nothing
	task automatic add_ignored(logic [7:0] b);
		beat_t t;
		t.data = b;
		t.np   = 1'b0;
		pending.push_back(t);
	endtask

	function automatic logic [7:0] rand_coord();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hEF;
			default: return 8'($urandom_range(0, 239));
		endcase
	endfunction

	// The opening pair is unchecked, so any byte may stand there
	function automatic logic [7:0] opening_coord();
		return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : rand_coord();
	endfunction

	task automatic build_line_cmd(logic [7:0] cmd);
		int n;
		n = $urandom_range(0, 8);
		add_beat(cmd);
		add_beat(opening_coord());
		// rarely drop the second opening byte so the next command lands there
		if ($urandom_range(0, 19) != 0) add_beat(opening_coord());
		repeat (n) add_beat(cmd == CMD_REL_LINE ? 8'($urandom_range(0, 239)) : rand_coord());
	endtask

	// One picture: fresh start, a run of commands, then an ending byte
	task automatic build_picture();
		int n_cmds;
		int n;
		n_cmds  = $urandom_range(3, 14);
		np_next = 1'b1;
		gen_pen = 8'h00;
		repeat (n_cmds) begin
			case ($urandom_range(0, 11))
				0: begin add_beat(CMD_VIS_ON); add_beat(8'($urandom_range(0, 255))); end
				1: add_beat(CMD_VIS_OFF);
				2: begin add_beat(CMD_PRI_ON); add_beat(8'($urandom_range(0, 255))); end
				3: add_beat(CMD_PRI_OFF);
				4: build_line_cmd(CMD_Y_CORNER);
				5: build_line_cmd(CMD_X_CORNER);
				6: build_line_cmd(CMD_ABS_LINE);
				7, 11: build_line_cmd(CMD_REL_LINE);
				8: begin
					n = $urandom_range(0, 4);
					add_beat(CMD_FILL);
					repeat (2 * n) add_beat(rand_coord());
					if ($urandom_range(0, 3) == 0) add_beat(rand_coord());
				end
				9: begin
					gen_pen = 8'($urandom_range(0, 255));
					add_beat(CMD_PEN);
					add_beat(gen_pen);
				end
				default: begin
					n = $urandom_range(0, 4);
					add_beat(CMD_BRUSH);
					repeat (n) begin
						if (gen_pen[PEN_SPLATTER_BIT]) add_beat(rand_coord());
						add_beat(rand_coord());
						add_beat(rand_coord());
					end
				end
			endcase
		end
		case ($urandom_range(0, 9))
			0: begin add_beat(CMD_VIS_OFF); add_beat(8'($urandom_range(0, 239))); end
			1: add_beat(8'($urandom_range(8'hFB, 8'hFE)));
			default: add_beat(CMD_END);
		endcase
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) add_ignored(8'($urandom_range(0, 255)));
	endtask

	// Hold the sender until every queued byte is taken and every primitive seen
	task automatic wait_drained();
		do @(posedge clk);
		while (pending.size() != 0 || in_valid || expected_prims.size() != 0);
	endtask

	task automatic run_random_phase(int send_pct, int recv_pct, int count);
		int target;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		target         = beats_queued + count;
		while (beats_queued < target) build_picture();
		wait_drained();
	endtask

	initial begin
		clear_picture_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: colours at the extremes, an unchecked pair of FF,
		// a relative step that wraps below zero, a splattered brush, a fill,
		// and an unknown FB code
		np_next = 1'b1;
		add_beat(CMD_VIS_ON);   add_beat(8'hFF);
		add_beat(CMD_PRI_ON);   add_beat(8'h00);
		add_beat(CMD_Y_CORNER); add_beat(8'hFF); add_beat(8'hFF);
		add_beat(8'h00);        add_beat(8'hEF);
		add_beat(CMD_REL_LINE); add_beat(8'h00); add_beat(8'h00);
		add_beat(8'h99);        add_beat(8'h0F);
		add_beat(CMD_PEN);      add_beat(8'h20);
		add_beat(CMD_BRUSH);    add_beat(8'h41); add_beat(8'h10); add_beat(8'h20);
		add_beat(CMD_FILL);     add_beat(8'h05); add_beat(8'h06);
		add_beat(CMD_VIS_OFF);  add_beat(8'hFB);
		add_ignored(8'h12);
		// second picture: odd absolute list, then a corner ended by the end code
		np_next = 1'b1;
		add_beat(CMD_PRI_OFF);
		add_beat(CMD_ABS_LINE); add_beat(8'h01); add_beat(8'h02); add_beat(8'h03);
		add_beat(CMD_X_CORNER); add_beat(8'h0A); add_beat(8'h0B); add_beat(8'h0C);
		add_beat(CMD_END);
		// a data byte where a command is due
		np_next = 1'b1;
		add_beat(8'h12);
		wait_drained();

		// Long hold-off on the output while the sender keeps pushing fill points
		np_next = 1'b1;
		add_beat(CMD_FILL);
		repeat (120) add_beat(rand_coord());
		add_beat(CMD_END);
		burst_asked++;
		wait_drained();

		np_noise_on = 1'b1;
		run_random_phase(0, 0, 360);
		run_random_phase(49, 0, 360);
		run_random_phase(0, 49, 360);
		run_random_phase(7, 7, 360);

		repeat (10) @(posedge clk);
		if (expected_prims.size() != 0) begin
			$display("%0t: %0d predicted primitives never arrived", $time,
				expected_prims.size());
			fail_count++;
		end
		$display("Run covered %0d bytes and %0d primitives", beats_taken, prims_checked);
		$display("  pixel %0d, line %0d, brush %0d, fill %0d, end %0d, error %0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
			kind_seen[5]);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
